// ===== design/rc2_pkg.sv =====
package rc2_pkg;

  localparam int WORD_W       = 16;
  localparam int BLOCK_W      = 64;
  localparam int KEY_REG_W    = 64;
  localparam int KEY_BYTES    = 128;
  localparam int KEY_WORDS    = 64;
  localparam int KW_AW        = 6;
  localparam int MIX_CELLS    = 64;

  // Effective key length, clamped to the meaningful range.
  localparam int EFF_BITS_RAW = 64;
  localparam int EFF_BITS     = (EFF_BITS_RAW > 1024) ? 1024 :
                                ((EFF_BITS_RAW < 1) ? 1 : EFF_BITS_RAW);
  localparam int KEY_T8       = (EFF_BITS + 7) / 8;
  localparam logic [7:0] KEY_TM = 8'(255 >> ((8 * KEY_T8 - EFF_BITS) % 8));

  // Forward fill of the expansion buffer, one byte per cycle.
  localparam int FWD_STEPS    = KEY_BYTES - 16;

  typedef logic [3:0][WORD_W-1:0]       word4_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] kwords_t;

  typedef struct packed {
    logic   vld;
    word4_t r;
  } link_t;

  typedef struct packed {
    logic              we;
    logic [KW_AW-1:0]  addr;
    logic [WORD_W-1:0] data;
  } kw_wr_t;

  localparam logic [7:0] PI_TABLE [256] = '{
    8'd217, 8'd120, 8'd249, 8'd196, 8'd25,  8'd221, 8'd181, 8'd237,
    8'd40,  8'd233, 8'd253, 8'd121, 8'd74,  8'd160, 8'd216, 8'd157,
    8'd198, 8'd126, 8'd55,  8'd131, 8'd43,  8'd118, 8'd83,  8'd142,
    8'd98,  8'd76,  8'd100, 8'd136, 8'd68,  8'd139, 8'd251, 8'd162,
    8'd23,  8'd154, 8'd89,  8'd245, 8'd135, 8'd179, 8'd79,  8'd19,
    8'd97,  8'd69,  8'd109, 8'd141, 8'd9,   8'd129, 8'd125, 8'd50,
    8'd189, 8'd143, 8'd64,  8'd235, 8'd134, 8'd183, 8'd123, 8'd11,
    8'd240, 8'd149, 8'd33,  8'd34,  8'd92,  8'd107, 8'd78,  8'd130,
    8'd84,  8'd214, 8'd101, 8'd147, 8'd206, 8'd96,  8'd178, 8'd28,
    8'd115, 8'd86,  8'd192, 8'd20,  8'd167, 8'd140, 8'd241, 8'd220,
    8'd18,  8'd117, 8'd202, 8'd31,  8'd59,  8'd190, 8'd228, 8'd209,
    8'd66,  8'd61,  8'd212, 8'd48,  8'd163, 8'd60,  8'd182, 8'd38,
    8'd111, 8'd191, 8'd14,  8'd218, 8'd70,  8'd105, 8'd7,   8'd87,
    8'd39,  8'd242, 8'd29,  8'd155, 8'd188, 8'd148, 8'd67,  8'd3,
    8'd248, 8'd17,  8'd199, 8'd246, 8'd144, 8'd239, 8'd62,  8'd231,
    8'd6,   8'd195, 8'd213, 8'd47,  8'd200, 8'd102, 8'd30,  8'd215,
    8'd8,   8'd232, 8'd234, 8'd222, 8'd128, 8'd82,  8'd238, 8'd247,
    8'd132, 8'd170, 8'd114, 8'd172, 8'd53,  8'd77,  8'd106, 8'd42,
    8'd150, 8'd26,  8'd210, 8'd113, 8'd90,  8'd21,  8'd73,  8'd116,
    8'd75,  8'd159, 8'd208, 8'd94,  8'd4,   8'd24,  8'd164, 8'd236,
    8'd194, 8'd224, 8'd65,  8'd110, 8'd15,  8'd81,  8'd203, 8'd204,
    8'd36,  8'd145, 8'd175, 8'd80,  8'd161, 8'd244, 8'd112, 8'd57,
    8'd153, 8'd124, 8'd58,  8'd133, 8'd35,  8'd184, 8'd180, 8'd122,
    8'd252, 8'd2,   8'd54,  8'd91,  8'd37,  8'd85,  8'd151, 8'd49,
    8'd45,  8'd93,  8'd250, 8'd152, 8'd227, 8'd138, 8'd146, 8'd174,
    8'd5,   8'd223, 8'd41,  8'd16,  8'd103, 8'd108, 8'd186, 8'd201,
    8'd211, 8'd0,   8'd230, 8'd207, 8'd225, 8'd158, 8'd168, 8'd44,
    8'd99,  8'd22,  8'd1,   8'd63,  8'd88,  8'd226, 8'd137, 8'd169,
    8'd13,  8'd56,  8'd52,  8'd27,  8'd171, 8'd51,  8'd255, 8'd176,
    8'd187, 8'd72,  8'd12,  8'd95,  8'd185, 8'd177, 8'd205, 8'd46,
    8'd197, 8'd243, 8'd219, 8'd71,  8'd229, 8'd165, 8'd156, 8'd119,
    8'd10,  8'd166, 8'd32,  8'd104, 8'd254, 8'd127, 8'd193, 8'd173
  };

endpackage

// ===== design/rc2_mix_cell.sv =====
module rc2_mix_cell
  import rc2_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        sel_i,
  input  logic [WORD_W-1:0] key_i,
  input  link_t             in_i,
  output logic              ready_o,
  output link_t             out_o,
  input  logic              ready_i
);

  logic              vld_q;
  word4_t            r_q;
  word4_t            r_d;
  logic [1:0]        s1, s2, s3;
  logic [WORD_W-1:0] cur, rot, p1, p2;

  // Undo one quarter round on the selected word.
  always_comb begin
    s1  = sel_i - 2'd1;
    s2  = sel_i - 2'd2;
    s3  = sel_i - 2'd3;
    cur = in_i.r[sel_i];
    unique case (sel_i)
      2'd0: rot = {cur[0],   cur[15:1]};
      2'd1: rot = {cur[1:0], cur[15:2]};
      2'd2: rot = {cur[2:0], cur[15:3]};
      2'd3: rot = {cur[4:0], cur[15:5]};
      default: rot = cur;
    endcase
    p1 = in_i.r[s1] & in_i.r[s2];
    p2 = ~in_i.r[s1] & in_i.r[s3];
    r_d = in_i.r;
    r_d[sel_i] = rot - key_i - p1 - p2;
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      r_q <= r_d;
    end
  end

  assign out_o.vld = vld_q;
  assign out_o.r   = r_q;

endmodule

// ===== design/rc2_mash_cell.sv =====
module rc2_mash_cell
  import rc2_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  kw_wr_t kw_wr_i,
  input  link_t  in_i,
  output logic   ready_o,
  output link_t  out_o,
  input  logic   ready_i
);

  // Two copies of the key words, two read ports each.
  logic [WORD_W-1:0] mem_a [KEY_WORDS];
  logic [WORD_W-1:0] mem_b [KEY_WORDS];

  logic              a_vld_q, b_vld_q;
  word4_t            a_r_q, b_r_q, a_r_d;
  logic [WORD_W-1:0] rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;
  logic              ready_a, ready_b;

  assign ready_b = !b_vld_q || ready_i;
  assign ready_a = !a_vld_q || ready_b;
  assign ready_o = ready_a;

  // Stage A: the three lookups that use incoming words.
  always_comb begin
    a_r_d    = a_r_q;
    a_r_d[3] = a_r_q[3] - rd_a0_q;
    a_r_d[2] = a_r_q[2] - rd_a1_q;
    a_r_d[1] = a_r_q[1] - rd_b0_q;
  end

  always_ff @(posedge clk_i) begin
    if (kw_wr_i.we) begin
      mem_a[kw_wr_i.addr] <= kw_wr_i.data;
      mem_b[kw_wr_i.addr] <= kw_wr_i.data;
    end
    if (ready_a) begin
      a_r_q   <= in_i.r;
      rd_a0_q <= mem_a[in_i.r[2][KW_AW-1:0]];
      rd_a1_q <= mem_a[in_i.r[1][KW_AW-1:0]];
      rd_b0_q <= mem_b[in_i.r[0][KW_AW-1:0]];
    end
    // Stage B: last lookup depends on the fresh word 3.
    if (ready_b) begin
      b_r_q   <= a_r_d;
      rd_b1_q <= mem_b[a_r_d[3][KW_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (ready_a) a_vld_q <= in_i.vld;
      if (ready_b) b_vld_q <= a_vld_q;
    end
  end

  always_comb begin
    out_o.vld    = b_vld_q;
    out_o.r      = b_r_q;
    out_o.r[0]   = b_r_q[0] - rd_b1_q;
  end

endmodule

// ===== design/rc2_key_sched.sv =====
module rc2_key_sched
  import rc2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic [KEY_REG_W-1:0] key_lo_i,
  input  logic [KEY_REG_W-1:0] key_hi_i,
  output logic                 busy_o,
  output kwords_t              keys_o,
  output kw_wr_t               kw_wr_o
);

  typedef enum logic [2:0] {
    KS_LOAD,
    KS_FWD,
    KS_BWD,
    KS_COPY,
    KS_DONE
  } ks_state_e;

  ks_state_e  state_q;
  logic [6:0] cnt_q;
  logic [7:0] kb_q [KEY_BYTES];
  logic [7:0] kb_d [KEY_BYTES];
  logic [7:0] fwd_sum;
  logic [7:0] bwd_new;

  assign fwd_sum = kb_q[KEY_BYTES-1] + kb_q[KEY_BYTES-16];

  // Backward pass: pass the untouched tail, mask the first byte, then fold.
  always_comb begin
    priority if (cnt_q < 7'(KEY_T8 - 1)) begin
      bwd_new = kb_q[KEY_BYTES-1];
    end else if (cnt_q == 7'(KEY_T8 - 1)) begin
      bwd_new = PI_TABLE[kb_q[KEY_BYTES-1] & KEY_TM];
    end else begin
      bwd_new = PI_TABLE[kb_q[0] ^ kb_q[KEY_T8-1]];
    end
  end

  always_comb begin
    kb_d = kb_q;
    unique case (state_q)
      KS_LOAD: begin
        for (int j = 0; j < 8; j++) begin
          kb_d[KEY_BYTES-16+j] = key_lo_i[8*j +: 8];
          kb_d[KEY_BYTES-8+j]  = key_hi_i[8*j +: 8];
        end
      end
      KS_FWD: begin
        for (int k = 0; k < KEY_BYTES - 1; k++) kb_d[k] = kb_q[k+1];
        kb_d[KEY_BYTES-1] = PI_TABLE[fwd_sum];
      end
      KS_BWD: begin
        for (int k = 1; k < KEY_BYTES; k++) kb_d[k] = kb_q[k-1];
        kb_d[0] = bwd_new;
      end
      KS_COPY: begin
        for (int k = 0; k < KEY_BYTES - 2; k++) kb_d[k] = kb_q[k+2];
        kb_d[KEY_BYTES-2] = kb_q[0];
        kb_d[KEY_BYTES-1] = kb_q[1];
      end
      KS_DONE: begin
        kb_d = kb_q;
      end
      default: begin
        kb_d = kb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    kb_q <= kb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_LOAD;
      cnt_q   <= '0;
    end else if (restart_i) begin
      state_q <= KS_LOAD;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        KS_LOAD: begin
          state_q <= KS_FWD;
          cnt_q   <= '0;
        end
        KS_FWD: begin
          if (cnt_q == 7'(FWD_STEPS - 1)) begin
            state_q <= KS_BWD;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        KS_BWD: begin
          if (cnt_q == 7'(KEY_BYTES - 1)) begin
            state_q <= KS_COPY;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        KS_COPY: begin
          if (cnt_q == 7'(KEY_WORDS - 1)) begin
            state_q <= KS_DONE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        KS_DONE: begin
          state_q <= KS_DONE;
        end
        default: begin
          state_q <= KS_LOAD;
          cnt_q   <= '0;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != KS_DONE);
  assign kw_wr_o.we   = (state_q == KS_COPY);
  assign kw_wr_o.addr = cnt_q[KW_AW-1:0];
  assign kw_wr_o.data = {kb_q[1], kb_q[0]};

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      keys_o[w] = {kb_q[2*w+1], kb_q[2*w]};
    end
  end

endmodule

// ===== design/rc2_block_decrypt_top.sv =====
// Channel   Dir  Beat            Handshake
// cipher    in   cipher_block_i  cipher_valid_i / cipher_stall_o
// plain     out  plain_block_o   plain_valid_o  / plain_stall_i
// config    in   pwdata (64 b)   APB write, key_bytes_low at 0x0, key_bytes_high at 0x8
//
// One beat enters per cycle while cipher_stall_o is low. The path is 64 quarter-round cells plus
// two mash cells of two stages each, every stage registered and stalling on its own.
// The key expander runs after reset and after every key write (load,
// 112 forward fill steps, 128 backward steps, 64 key memory writes); hold
// cipher_stall_o high for all of that time.
// A stall on plain_stall_i backs up stage by stage, so empty stages still take beats.
module rc2_block_decrypt_top
  import rc2_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               cipher_valid_i,
  output logic               cipher_stall_o,
  input  logic [BLOCK_W-1:0] cipher_block_i,
  output logic               plain_valid_o,
  input  logic               plain_stall_i,
  output logic [BLOCK_W-1:0] plain_block_o
);

  localparam int NUM_ELEMS = MIX_CELLS + 2;
  localparam int MASH0_POS = 20;
  localparam int MASH1_POS = 45;

  logic [KEY_REG_W-1:0] key_lo_q, key_hi_q;
  logic                 cfg_wr;
  logic                 busy;
  kwords_t              keys;
  kw_wr_t               kw_wr;

  link_t link  [NUM_ELEMS+1];
  logic  ready [NUM_ELEMS+1];

  // Config port: always ready, decode on the 8-byte register slot.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? key_hi_q : key_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) key_hi_q <= pwdata;
      else          key_lo_q <= pwdata;
    end
  end

  // Rebuild the schedule whenever a key register is written.
  rc2_key_sched u_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .key_lo_i  (key_lo_q),
    .key_hi_i  (key_hi_q),
    .busy_o    (busy),
    .keys_o    (keys),
    .kw_wr_o   (kw_wr)
  );

  // Drop incoming beats into the chain only when the schedule is ready.
  assign link[0].vld     = cipher_valid_i && !busy;
  assign link[0].r       = cipher_block_i;
  assign cipher_stall_o  = busy || !ready[0];

  // Rounds 15 down to 0, each as four cells: word 3, 2, 1, 0.
  // Cell c uses key word 63 - c; mash follows rounds 11 and 5.
  for (genvar c = 0; c < MIX_CELLS; c++) begin : g_mix
    localparam int POS = c + ((c > 19) ? 1 : 0) + ((c > 43) ? 1 : 0);
    rc2_mix_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (2'(3 - (c % 4))),
      .key_i   (keys[MIX_CELLS-1-c]),
      .in_i    (link[POS]),
      .ready_o (ready[POS]),
      .out_o   (link[POS+1]),
      .ready_i (ready[POS+1])
    );
  end

  rc2_mash_cell u_mash_r11 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kw_wr_i (kw_wr),
    .in_i    (link[MASH0_POS]),
    .ready_o (ready[MASH0_POS]),
    .out_o   (link[MASH0_POS+1]),
    .ready_i (ready[MASH0_POS+1])
  );

  rc2_mash_cell u_mash_r5 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kw_wr_i (kw_wr),
    .in_i    (link[MASH1_POS]),
    .ready_o (ready[MASH1_POS]),
    .out_o   (link[MASH1_POS+1]),
    .ready_i (ready[MASH1_POS+1])
  );

  // The last cell's register is the output register.
  assign ready[NUM_ELEMS] = !plain_stall_i;
  assign plain_valid_o    = link[NUM_ELEMS].vld;
  assign plain_block_o    = link[NUM_ELEMS].r;

  // No beat may enter while the schedule is being rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> cipher_stall_o)
    else $error("beat accepted during key expansion");

  // A key write always restarts the expander.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_wr |=> busy)
    else $error("key write did not restart expansion");

  // Key memories are only written by the expander sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) kw_wr.we |-> busy)
    else $error("key memory written while idle");

endmodule

// ===== tb/rc2_block_decrypt_top_test.sv =====
`timescale 1ns / 1ps

import rc2_pkg::*;

typedef enum int {
  KEY_REG_LOW  = 0,
  KEY_REG_HIGH = 1
} key_reg_e;

localparam int KEY_LEN_BITS = 64;

class rc2_plain_scoreboard;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [15:0] sched[64];
  logic [63:0] plain_q[$];
  int unsigned n_err;

  function new();
    key_lo = '0;
    key_hi = '0;
    n_err  = 0;
    expand_key();
  endfunction

  function void expand_key();
    logic [7:0] lb[128];
    int bits;
    int t8;
    logic [7:0] tm;
    bits = KEY_LEN_BITS;
    if (bits > 1024) bits = 1024;
    if (bits < 1) bits = 1;
    for (int i = 0; i < 8; i++) begin
      lb[i]     = key_lo[8*i +: 8];
      lb[i + 8] = key_hi[8*i +: 8];
    end
    for (int i = 16; i < 128; i++) lb[i] = PI_TABLE[8'(lb[i-1] + lb[i-16])];
    t8 = (bits + 7) >> 3;
    tm = 8'hFF >> ((8 * t8 - bits) & 7);
    lb[128 - t8] = PI_TABLE[lb[128 - t8] & tm];
    for (int i = 128 - t8; i > 0; i--) lb[i-1] = PI_TABLE[lb[i] ^ lb[i - 1 + t8]];
    for (int i = 0; i < 64; i++) sched[i] = {lb[2*i + 1], lb[2*i]};
  endfunction

  function void write_key(key_reg_e r, logic [63:0] v);
    case (r)
      KEY_REG_LOW:  key_lo = v;
      KEY_REG_HIGH: key_hi = v;
      default: return;
    endcase
    expand_key();
  endfunction

  function logic [15:0] ror16(logic [15:0] v, int s);
    return (v >> s) | (v << (16 - s));
  endfunction

  function logic [63:0] decrypt(logic [63:0] c);
    logic [15:0] r0, r1, r2, r3;
    int b;
    r0 = c[15:0];
    r1 = c[31:16];
    r2 = c[47:32];
    r3 = c[63:48];
    for (int rnd = 15; rnd >= 0; rnd--) begin
      b  = 4 * rnd;
      r3 = ror16(r3, 5) - sched[b + 3] - (r2 & r1) - (~r2 & r0);
      r2 = ror16(r2, 3) - sched[b + 2] - (r1 & r0) - (~r1 & r3);
      r1 = ror16(r1, 2) - sched[b + 1] - (r0 & r3) - (~r0 & r2);
      r0 = ror16(r0, 1) - sched[b]     - (r3 & r2) - (~r3 & r1);
      if (rnd == 11 || rnd == 5) begin
        r3 = r3 - sched[r2[5:0]];
        r2 = r2 - sched[r1[5:0]];
        r1 = r1 - sched[r0[5:0]];
        r0 = r0 - sched[r3[5:0]];
      end
    end
    return {r3, r2, r1, r0};
  endfunction

  function void note_cipher(logic [63:0] c);
    plain_q = {plain_q, decrypt(c)};
  endfunction

  function void check_plain(logic [63:0] p);
    logic [63:0] want;
    if (plain_q.size() == 0) begin
      n_err++;
      $display("%0t: unexpected plain block %h", $time, p);
      return;
    end
    want = plain_q.pop_front();
    if (p !== want) begin
      n_err++;
      $display("%0t: plain_block mismatch: expected %h, actual %h", $time, want, p);
    end
  endfunction

  function int pending();
    return plain_q.size();
  endfunction
endclass

module rc2_block_decrypt_top_test;

  // Settle time after a key write, long enough for the expander to finish, with margin.
  localparam int KEY_SETTLE = 400;
  // Pipeline is 68 stages deep; drain for a bit more than that at the end.
  localparam int DRAIN      = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 210;
  localparam int HOLD_CYCLES = 400;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [3:0]         paddr          = '0;
  logic [63:0]        pwdata         = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               cipher_valid_i = 1'b0;
  logic               cipher_stall_o;
  logic [BLOCK_W-1:0] cipher_block_i = '0;
  logic               plain_valid_o;
  logic               plain_stall_i  = 1'b0;
  logic [BLOCK_W-1:0] plain_block_o;

  rc2_plain_scoreboard sb = new();

  // Idle controls set by the main flow for the sender and the receiver processes.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold    = 0;
  int unsigned cycles = 0;

  rc2_block_decrypt_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cipher_valid_i (cipher_valid_i),
    .cipher_stall_o (cipher_stall_o),
    .cipher_block_i (cipher_block_i),
    .plain_valid_o  (plain_valid_o),
    .plain_stall_i  (plain_stall_i),
    .plain_block_o  (plain_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL rc2_block_decrypt_top");
      $finish;
    end
  end

  // Check every plain beat taken at this edge against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && plain_valid_o && !plain_stall_i) sb.check_plain(plain_block_o);
  end

  // Receiver: stall a drawn number of cycles before each beat, or a long
  // hold-off when the main flow requests one.
  initial begin : plain_sink
    int n;
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else if (rx_idle_en && $urandom_range(0, 2) != 0) begin
        n = $urandom_range(0, 17);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        plain_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        plain_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!plain_valid_o);
    end
  end

  // Write one key register: setup cycle, then access until pready.
  // Hold off afterwards so the expander finishes before anything else.
  task automatic write_key_reg(key_reg_e r, logic [63:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(int'(r) << 3);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_key(r, v);
    repeat (KEY_SETTLE) @(posedge clk_i);
  endtask

  // Offer one cipher beat after a drawn gap; return at the edge it is taken.
  // Valid stays high across back-to-back beats.
  task automatic send_cipher(logic [63:0] blk);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      cipher_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cipher_valid_i <= 1'b1;
    cipher_block_i <= blk;
    do @(posedge clk_i); while (cipher_stall_o);
    sb.note_cipher(blk);
  endtask

  // Drop valid and wait until every predicted plain block has come back.
  task automatic drain_plain();
    cipher_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : main_flow
    logic [63:0] edge_blocks[15];
    logic [63:0] lo, hi;

    edge_blocks = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h0000_FFFF_0000_FFFF, 64'hFFFF_0000_FFFF_0000,
                    64'h8000_8000_8000_8000, 64'h0001_0001_0001_0001,
                    64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h0123_4567_89AB_CDEF,
                    64'hFEDC_BA98_7654_3210, 64'h003F_003F_003F_003F,
                    64'hFFC0_FFC0_FFC0_FFC0};

    // Reset once; the expander then runs its pass on the all-zero key.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed blocks under the reset key, back to back.
    tx_idle_en = 1'b0;
    foreach (edge_blocks[i]) send_cipher(edge_blocks[i]);
    drain_plain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Pick keys: extremes first, then random, some phases touching one register.
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (ph)
        0: begin
          write_key_reg(KEY_REG_LOW, '1);
          write_key_reg(KEY_REG_HIGH, '1);
        end
        1: begin
          write_key_reg(KEY_REG_LOW, '0);
          write_key_reg(KEY_REG_HIGH, '0);
        end
        2: begin
          write_key_reg(KEY_REG_LOW, '1);
          write_key_reg(KEY_REG_HIGH, '0);
        end
        5: write_key_reg(KEY_REG_LOW, lo);
        6: write_key_reg(KEY_REG_HIGH, hi);
        default: begin
          write_key_reg(KEY_REG_LOW, lo);
          write_key_reg(KEY_REG_HIGH, hi);
        end
      endcase

      // Vary which side idles; phase 3 has neither idling.
      tx_idle_en = (ph % 4 != 1) && (ph != 3);
      rx_idle_en = (ph % 4 != 2) && (ph != 3);

      // Long receiver hold-off with a busy sender: fill the pipe and
      // push the stall back to the input.
      if (ph == 1) rx_hold = HOLD_CYCLES;

      if (ph == 2) foreach (edge_blocks[i]) send_cipher(edge_blocks[i]);

      for (int k = 0; k < PHASE_BEATS; k++) begin
        send_cipher({$urandom, $urandom});
        // Pause the sender mid-phase until the pipe is empty.
        if (ph == 4 && k == PHASE_BEATS / 2) drain_plain();
      end
      drain_plain();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("PASS rc2_block_decrypt_top");
    end else begin
      $display("FAIL rc2_block_decrypt_top");
    end
    $finish;
  end

endmodule
